// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared shorthand for clocked concurrent assertions with async reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/ipd_pkg.sv -----
// ----------------------------------------------------------------------------
// ipd_pkg
// types, codes and constants shared by the ipd deframer files
// ----------------------------------------------------------------------------
package ipd_pkg;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_CAP = 8'd1;

	localparam logic [15:0] MAX_FRAME_LEN_RST = 16'd4095;
	localparam logic [15:0] PAYLOAD_CAP_RST = 16'd1599;

	localparam logic [2:0] PREFIX_LEN = 3'd5;

	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_OVERSIZE = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		PH_HUNT = 4'b0001,
		PH_ID = 4'b0010,
		PH_LEN = 4'b0100,
		PH_DATA = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [15:0] max_frame_len;
		logic [15:0] payload_cap;
	} cfg_t;

	typedef struct packed {
		logic [7:0] link_id;
		logic [7:0] data_byte;
		kind_t kind;
		logic last;
	} result_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = CH_PLUS;
			3'd1: ch = CH_I;
			3'd2: ch = CH_P;
			3'd3: ch = CH_D;
			3'd4: ch = CH_COMMA;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ----- rtl/ipd_if.sv -----
// ----------------------------------------------------------------------------
// ipd channel interfaces
// valid/ready channels for received bytes, results and register writes
// ----------------------------------------------------------------------------
interface ipd_rx_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ipd_res_if;
	logic valid;
	logic ready;
	logic [7:0] link_id;
	logic [7:0] data_byte;
	logic [1:0] kind;
	logic last;
	modport source (output valid, output link_id, output data_byte, output kind,
		output last, input ready);
	modport sink (input valid, input link_id, input data_byte, input kind,
		input last, output ready);
endinterface

interface ipd_cfg_if;
	logic valid;
	logic ready;
	logic [ipd_pkg::CFG_IDX_W-1:0] index;
	logic [ipd_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ipd_frame_deframer_top.sv -----
// ----------------------------------------------------------------------------
// ipd_frame_deframer_top
// streaming deframer for modem "+IPD,<id>,<len>:" data notices
// ----------------------------------------------------------------------------
// usage:
//   rx  : one received modem byte per transaction (valid/ready)
//   res : zero or one result per byte: payload byte, empty frame or
//         oversize frame, tagged with the link id and a last mark
//   cfg : register writes, index 0 max_frame_len, index 1 payload_cap;
//         always ready, write only while no byte is in flight
//   throughput: one byte per cycle while res does not hold off a result;
//         a byte register feeds the parse logic, which loads a result
//         register, so both sides run back to back
//   stall: when res is held off with a result pending, a full byte register
//         holds and rx.ready drops in the same cycle; bytes that give no
//         result still pass through whenever the result register is free
//   reset: arst_n clears the parse state to prefix hunt, empties both
//         registers and loads the register defaults (4095 and 1599)
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipd_frame_deframer_top #(
	parameter int LENGTH_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	ipd_rx_if.sink rx,
	ipd_res_if.source res,
	ipd_cfg_if.sink cfg
);

	ipd_pkg::cfg_t cfg_q;
	logic valid_s1;
	logic [7:0] byte_s1;
	logic res_valid_q;
	ipd_pkg::result_t res_q;
	logic advance;
	logic step_en;
	logic parse_valid;
	ipd_pkg::result_t parse_res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_frame_len <= ipd_pkg::MAX_FRAME_LEN_RST;
			cfg_q.payload_cap <= ipd_pkg::PAYLOAD_CAP_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				ipd_pkg::REG_MAX_FRAME_LEN: cfg_q.max_frame_len <= cfg.data;
				ipd_pkg::REG_PAYLOAD_CAP: cfg_q.payload_cap <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign advance = !res_valid_q || res.ready;
	assign step_en = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	ipd_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(step_en),
		.rx_byte(byte_s1),
		.cfg(cfg_q),
		.res_valid(parse_valid),
		.res(parse_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= step_en && parse_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && parse_valid) begin
			res_q <= parse_res;
		end
	end

	assign res.valid = res_valid_q;
	assign res.link_id = res_q.link_id;
	assign res.data_byte = res_q.data_byte;
	assign res.kind = res_q.kind;
	assign res.last = res_q.last;

	`ASSERT_IMPLIES(a_ctrl_last, clk, arst_n,
		res_valid_q && (res_q.kind != ipd_pkg::KIND_DATA), res_q.last)
	`ASSERT_IMPLIES(a_ctrl_zero_data, clk, arst_n,
		res_valid_q && (res_q.kind != ipd_pkg::KIND_DATA), res_q.data_byte == 8'h00)
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n,
		!rx.ready, valid_s1 && res_valid_q && !res.ready)
	`ASSERT_NEXT(a_byte_held, clk, arst_n,
		valid_s1 && !advance, valid_s1 && (byte_s1 == $past(byte_s1)))

endmodule

// ----- rtl/ipd_parser.sv -----
// ----------------------------------------------------------------------------
// ipd_parser
// header parse state and per-byte result decision for the deframer
// ----------------------------------------------------------------------------
module ipd_parser #(
	parameter int LENGTH_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic step_en,
	input logic [7:0] rx_byte,
	input ipd_pkg::cfg_t cfg,
	output logic res_valid,
	output ipd_pkg::result_t res
);

	localparam int LB = LENGTH_BITS;
	localparam int WIDE_W = ((LB > 16) ? LB : 16) + 1;

	ipd_pkg::phase_t phase_q, phase_d;
	logic [2:0] pm_q, pm_d;
	logic [7:0] id_q, id_d;
	logic [LB-1:0] len_q, len_d;
	logic [7:0] hc_q, hc_d;
	logic [LB-1:0] pidx_q, pidx_d;

	logic is_digit;
	logic [3:0] digit;
	logic [2:0] hunt_base;
	logic [2:0] hunt_pm;
	logic hunt_done;
	logic go_hunt;
	logic [7:0] hc_inc;
	logic [LB+3:0] len_mul;
	logic [LB-1:0] len_sat;
	logic oversize;
	logic [LB:0] pidx_nxt;
	logic under_cap;
	logic at_end;

	assign is_digit = (rx_byte >= ipd_pkg::CH_ZERO) && (rx_byte <= ipd_pkg::CH_NINE);
	assign digit = rx_byte[3:0];

	// prefix matcher, restarts from zero outside the hunt phase
	assign hunt_base = (phase_q == ipd_pkg::PH_HUNT) ? pm_q : 3'd0;
	always_comb begin
		if (rx_byte == ipd_pkg::prefix_char(hunt_base)) begin
			hunt_pm = hunt_base + 3'd1;
		end else begin
			hunt_pm = (rx_byte == ipd_pkg::CH_PLUS) ? 3'd1 : 3'd0;
		end
	end
	assign hunt_done = (hunt_pm == ipd_pkg::PREFIX_LEN);

	assign hc_inc = (hc_q == 8'hFF) ? hc_q : hc_q + 8'd1;

	assign len_mul = ({4'd0, len_q} << 3) + ({4'd0, len_q} << 1) + (LB+4)'(digit);
	assign len_sat = (|len_mul[LB+3:LB]) ? {LB{1'b1}} : len_mul[LB-1:0];

	assign oversize = (WIDE_W'(hc_inc) + WIDE_W'(len_q)) > WIDE_W'(cfg.max_frame_len);

	assign pidx_nxt = {1'b0, pidx_q} + (LB+1)'(1);
	assign under_cap = WIDE_W'(pidx_q) < WIDE_W'(cfg.payload_cap);
	assign at_end = pidx_nxt >= {1'b0, len_q};

	always_comb begin
		phase_d = phase_q;
		pm_d = pm_q;
		id_d = id_q;
		len_d = len_q;
		hc_d = hc_q;
		pidx_d = pidx_q;
		go_hunt = 1'b0;
		res_valid = 1'b0;
		res.link_id = id_q;
		res.data_byte = 8'h00;
		res.kind = ipd_pkg::KIND_DATA;
		res.last = 1'b0;

		case (phase_q)
			ipd_pkg::PH_ID: begin
				if (is_digit) begin
					id_d = (id_q << 3) + (id_q << 1) + {4'd0, digit};
					hc_d = hc_inc;
				end else if (rx_byte == ipd_pkg::CH_COMMA) begin
					hc_d = hc_inc;
					len_d = '0;
					phase_d = ipd_pkg::PH_LEN;
				end else begin
					go_hunt = 1'b1;
				end
			end
			ipd_pkg::PH_LEN: begin
				if (is_digit) begin
					len_d = len_sat;
					hc_d = hc_inc;
				end else if (rx_byte == ipd_pkg::CH_COLON) begin
					hc_d = hc_inc;
					if (oversize) begin
						res_valid = 1'b1;
						res.kind = ipd_pkg::KIND_OVERSIZE;
						res.last = 1'b1;
						phase_d = ipd_pkg::PH_HUNT;
						pm_d = 3'd0;
					end else if (len_q == '0) begin
						res_valid = 1'b1;
						res.kind = ipd_pkg::KIND_EMPTY;
						res.last = 1'b1;
						phase_d = ipd_pkg::PH_HUNT;
						pm_d = 3'd0;
					end else begin
						pidx_d = '0;
						phase_d = ipd_pkg::PH_DATA;
					end
				end else begin
					go_hunt = 1'b1;
				end
			end
			ipd_pkg::PH_DATA: begin
				if (under_cap) begin
					res_valid = 1'b1;
					res.data_byte = rx_byte;
					res.last = (WIDE_W'(pidx_nxt) == WIDE_W'(len_q)) ||
						(WIDE_W'(pidx_nxt) == WIDE_W'(cfg.payload_cap));
				end
				pidx_d = pidx_nxt[LB-1:0];
				if (at_end) begin
					phase_d = ipd_pkg::PH_HUNT;
					pm_d = 3'd0;
				end
			end
			default: begin
				go_hunt = 1'b1;
			end
		endcase

		if (go_hunt) begin
			phase_d = ipd_pkg::PH_HUNT;
			pm_d = hunt_pm;
			if (hunt_done) begin
				phase_d = ipd_pkg::PH_ID;
				pm_d = 3'd0;
				id_d = 8'h00;
				len_d = '0;
				hc_d = {5'd0, ipd_pkg::PREFIX_LEN};
				pidx_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ipd_pkg::PH_HUNT;
			pm_q <= 3'd0;
			id_q <= 8'h00;
			len_q <= '0;
			hc_q <= 8'h00;
			pidx_q <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			pm_q <= pm_d;
			id_q <= id_d;
			len_q <= len_d;
			hc_q <= hc_d;
			pidx_q <= pidx_d;
		end
	end

endmodule
